>>> rtl/core/pmfd_pkg.sv
// shared types, constants and opcodes for the paged mono framebuffer draw engine
package pmfd_pkg;

    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 64;

    localparam logic [2:0] OP_SET   = 3'd0;
    localparam logic [2:0] OP_GET   = 3'd1;
    localparam logic [2:0] OP_HLINE = 3'd2;
    localparam logic [2:0] OP_VLINE = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;
    localparam logic [2:0] OP_RDBYTE = 3'd5;

    localparam logic [1:0] COLOR_BLACK   = 2'd0;
    localparam logic [1:0] COLOR_INVERSE = 2'd2;

    localparam logic [1:0] CFG_ROTATION = 2'd0;
    localparam logic [1:0] CFG_WIDTH    = 2'd1;
    localparam logic [1:0] CFG_HEIGHT   = 2'd2;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
        logic signed [15:0] length;
        logic [1:0]         color;
        logic [9:0]         byte_address;
    } in_item_t;

    typedef struct packed {
        logic       pixel_on;
        logic [7:0] byte_data;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ADDR,
        ST_READ,
        ST_WRITE,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input item, reset step counter
        logic clr_start; // start clearing sweep
        logic clr_step;  // write zero and advance clear pointer
        logic locate;    // register address for current step
        logic rd;        // issue memory read
        logic wr;        // write modified byte
        logic step;      // advance line position
        logic result;    // build result into output register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic is_line;
        logic is_clear;
        logic is_paint;
        logic steps_left;
        logic hit;
    } dp_status_t;

endpackage

>>> rtl/core/paged_mono_framebuffer_draw_top.sv
// top level of the paged monochrome framebuffer pixel and line engine
// One transaction on s_ carries an operation; exactly one result transaction on m_ follows.
// Set, get, read byte and the unused codes step through locate, ram read, modify/write
// and result into the output register, and the next transaction is taken only once the
// engine is back in idle; a line steps through locate, read and modify/write for every
// pixel of its length, on panel or not, since every pixel is a read-modify-write
// through the single store port; a zero or negative length touches no pixel; clear
// sweeps the whole store one byte a cycle. A new transaction is taken while the
// previous result still waits on m_; the engine then holds in its result state until
// m_ready frees the output register. After reset the same clearing sweep runs before
// the first transaction is taken. Config writes take effect at once and belong only
// where no transaction is in flight.
module paged_mono_framebuffer_draw_top #(
    parameter int MAX_WIDTH  = pmfd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = pmfd_pkg::MAX_HEIGHT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration write port
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    // command channel
    input  logic                s_valid,
    output logic                s_ready,
    input  pmfd_pkg::in_item_t  s_data,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output pmfd_pkg::out_item_t m_data
);
    pmfd_pkg::dp_cmd_t    cmd;
    pmfd_pkg::dp_status_t sts;

    // sequencer
    pmfd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // store, mapping and result register
    pmfd_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (s_data),
        .out_item  (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );
endmodule

>>> rtl/core/pmfd_ram.sv
// generic single port ram with registered read
module pmfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> rtl/core/pmfd_ctrl.sv
// controller state machine for the draw engine
module pmfd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  pmfd_pkg::dp_status_t sts,
    output pmfd_pkg::dp_cmd_t   cmd
);
    pmfd_pkg::state_t state_reg, state_next;
    logic             ovalid_reg, ovalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= pmfd_pkg::ST_INIT;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;

    always_comb begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg && !out_ready;
        cmd         = '0;
        in_ready    = 1'b0;
        unique case (state_reg)
            pmfd_pkg::ST_INIT: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = pmfd_pkg::ST_IDLE;
                end
            end
            pmfd_pkg::ST_IDLE: begin
                // a waiting result sits in its own register, so a new item can start
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = pmfd_pkg::ST_ADDR;
                end
            end
            pmfd_pkg::ST_ADDR: begin
                if (sts.is_clear) begin
                    cmd.clr_step = 1'b1;
                    if (sts.clr_last) begin
                        state_next = pmfd_pkg::ST_DONE;
                    end
                end else if (sts.is_line && !sts.steps_left) begin
                    state_next = pmfd_pkg::ST_DONE;
                end else begin
                    cmd.locate = 1'b1;
                    state_next = pmfd_pkg::ST_READ;
                end
            end
            pmfd_pkg::ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = pmfd_pkg::ST_WRITE;
            end
            pmfd_pkg::ST_WRITE: begin
                if (sts.is_paint) begin
                    cmd.wr = sts.hit;
                end
                if (sts.is_line) begin
                    cmd.step   = 1'b1;
                    state_next = pmfd_pkg::ST_ADDR;
                end else begin
                    state_next = pmfd_pkg::ST_DONE;
                end
            end
            pmfd_pkg::ST_DONE: begin
                if (!ovalid_reg || out_ready) begin
                    cmd.result  = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = pmfd_pkg::ST_IDLE;
                end
            end
            default: state_next = pmfd_pkg::ST_IDLE;
        endcase
        if (state_reg == pmfd_pkg::ST_INIT || state_reg == pmfd_pkg::ST_IDLE) begin
            cmd.clr_start = 1'b0;
        end
        if (cmd.load) begin
            cmd.clr_start = 1'b1;
        end
    end
endmodule

>>> rtl/core/pmfd_dp.sv
// datapath: item registers, coordinate mapping, address and store access
module pmfd_dp #(
    parameter int MAX_WIDTH  = pmfd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = pmfd_pkg::MAX_HEIGHT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    input  pmfd_pkg::in_item_t   in_item,
    output pmfd_pkg::out_item_t  out_item,
    input  pmfd_pkg::dp_cmd_t    cmd,
    output pmfd_pkg::dp_status_t sts
);
    localparam int PAGES = (MAX_HEIGHT + 7) / 8;
    localparam int DEPTH = MAX_WIDTH * PAGES;
    localparam int AW    = $clog2(DEPTH);

    logic [1:0] rot_reg;
    logic [7:0] pw_reg;
    logic [6:0] ph_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_reg <= 2'd0;
            pw_reg  <= 8'd128;
            ph_reg  <= 7'd64;
        end else if (cfg_we) begin
            case (cfg_index)
                pmfd_pkg::CFG_ROTATION: rot_reg <= cfg_data[1:0];
                pmfd_pkg::CFG_WIDTH:    pw_reg  <= cfg_data;
                pmfd_pkg::CFG_HEIGHT:   ph_reg  <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // effective panel size, saturated
    logic signed [19:0] w_eff, h_eff;
    assign w_eff = (32'(pw_reg) > MAX_WIDTH) ? 20'(MAX_WIDTH) : 20'(pw_reg);
    assign h_eff = (32'(ph_reg) > MAX_HEIGHT) ? 20'(MAX_HEIGHT) : 20'(ph_reg);

    pmfd_pkg::in_item_t item_reg;
    logic signed [19:0] cx_reg, cy_reg;
    logic signed [16:0] left_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= in_item;
            cx_reg   <= 20'(in_item.x_coord);
            cy_reg   <= 20'(in_item.y_coord);
            left_reg <= 17'(in_item.length);
        end else if (cmd.step) begin
            if (item_reg.operation == pmfd_pkg::OP_HLINE) begin
                cx_reg <= cx_reg + 20'sd1;
            end else begin
                cy_reg <= cy_reg + 20'sd1;
            end
            left_reg <= left_reg - 17'sd1;
        end
    end

    // rotation map
    logic signed [19:0] px, py;
    always_comb begin
        case (rot_reg)
            2'd1:    begin px = w_eff - cy_reg - 20'sd1; py = cx_reg; end
            2'd2:    begin px = w_eff - cx_reg - 20'sd1; py = h_eff - cy_reg - 20'sd1; end
            2'd3:    begin px = cy_reg; py = h_eff - cx_reg - 20'sd1; end
            default: begin px = cx_reg; py = cy_reg; end
        endcase
    end

    logic on_panel;
    assign on_panel = (px >= 0) && (px < w_eff) && (py >= 0) && (py < h_eff);

    logic [19:0] lin_addr;
    assign lin_addr = 20'(px) + 20'(py >>> 3) * 20'(w_eff);

    logic [AW-1:0] addr_reg;
    logic [7:0]    mask_reg;
    logic          hit_reg;
    logic [AW:0]   clr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.locate) begin
            if (item_reg.operation == pmfd_pkg::OP_RDBYTE) begin
                addr_reg <= AW'(item_reg.byte_address);
                hit_reg  <= 32'(item_reg.byte_address) < DEPTH;
            end else begin
                addr_reg <= AW'(lin_addr);
                hit_reg  <= on_panel && (lin_addr < 20'(DEPTH));
            end
            mask_reg <= 8'(8'd1 << py[2:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_start) begin
            clr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata, ram_rdata, mod_byte;
    logic          ram_we;

    always_comb begin
        case (item_reg.color)
            pmfd_pkg::COLOR_BLACK:   mod_byte = ram_rdata & ~mask_reg;
            pmfd_pkg::COLOR_INVERSE: mod_byte = ram_rdata ^ mask_reg;
            default:                 mod_byte = ram_rdata | mask_reg;
        endcase
    end

    assign ram_we    = cmd.clr_step || cmd.wr;
    assign ram_addr  = cmd.clr_step ? clr_reg[AW-1:0] : addr_reg;
    assign ram_wdata = cmd.clr_step ? 8'd0 : mod_byte;

    pmfd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // read data lands in the cycle after rd; capture it for the result
    logic [7:0] rd_byte_reg;
    logic       rd_pend_reg;
    always_ff @(posedge aclk) begin
        rd_pend_reg <= cmd.rd;
    end
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rd_byte_reg <= 8'd0;
        end else if (rd_pend_reg) begin
            rd_byte_reg <= ram_rdata;
        end
    end

    logic is_op_valid;
    assign is_op_valid = item_reg.operation == pmfd_pkg::OP_SET
                      || item_reg.operation == pmfd_pkg::OP_GET
                      || item_reg.operation == pmfd_pkg::OP_RDBYTE;

    pmfd_pkg::out_item_t out_reg, out_next;

    always_comb begin
        out_next = '0;
        if (hit_reg && is_op_valid) begin
            if (item_reg.operation == pmfd_pkg::OP_GET) begin
                out_next.pixel_on = |(rd_byte_reg & mask_reg);
            end else if (item_reg.operation == pmfd_pkg::OP_RDBYTE) begin
                out_next.byte_data = rd_byte_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.result) begin
            out_reg <= out_next;
        end
    end

    assign out_item = out_reg;

    assign sts.clr_last   = clr_reg == (AW+1)'(DEPTH - 1);
    assign sts.is_line    = item_reg.operation == pmfd_pkg::OP_HLINE
                         || item_reg.operation == pmfd_pkg::OP_VLINE;
    assign sts.is_clear   = item_reg.operation == pmfd_pkg::OP_CLEAR;
    assign sts.is_paint   = item_reg.operation == pmfd_pkg::OP_SET || sts.is_line;
    assign sts.steps_left = left_reg > 17'sd0;
    assign sts.hit        = hit_reg;
endmodule
